>>> src/scpd_pkg.sv
// Package for the scancode prefix decoder: request and result payload types,
// prefix mode encoding and scancode constants. No dependencies.
package scpd_pkg;

    localparam int BYTE_W = 8;
    localparam int CODE_W = 24;

    localparam logic [BYTE_W-1:0] SC_EXT      = 8'hE0;
    localparam logic [BYTE_W-1:0] SC_PAUSE    = 8'hE1;
    localparam logic [BYTE_W-1:0] SC_PRT_MAKE = 8'h2A;
    localparam logic [BYTE_W-1:0] SC_PRT_BRK  = 8'hB7;

    localparam logic [CODE_W-1:0] CODE_PAUSE_SEED = 24'h0000E1;
    localparam logic [CODE_W-1:0] CODE_PRT_BASE   = 24'h00E000;
    localparam logic [CODE_W-1:0] CODE_PRT_RAW    = 24'hE0372A;
    localparam logic [CODE_W-1:0] CODE_PRT_NORM   = 24'hE02A37;

    localparam logic [1:0] LEFT_EXT   = 2'd1;
    localparam logic [1:0] LEFT_PAUSE = 2'd2;

    typedef enum logic [3:0] {
        MODE_NONE  = 4'b0001,
        MODE_EXT   = 4'b0010,
        MODE_PAUSE = 4'b0100,
        MODE_PRINT = 4'b1000
    } t_mode;

    typedef struct packed {
        logic [BYTE_W-1:0] scan_byte;
    } t_scan_req;

    typedef struct packed {
        logic [CODE_W-1:0] key_code;
        logic              released;
    } t_key_evt;

    typedef struct packed {
        logic     has;
        t_key_evt evt;
    } t_step_res;

endpackage

>>> src/scpd_stream_if.sv
// Valid/ready stream interface carrying one payload of type T.
// Used by the scancode prefix decoder for its input and output channels.
interface scpd_stream_if #(
    parameter type T = logic [7:0]
);
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

>>> src/scancode_prefix_decoder.sv
// Top level of the scancode prefix decoder: input register, decode stage,
// output register. Depends on scpd_pkg, scpd_stream_if, scpd_in_stage, scpd_decode.
//
//  channel  | dir | payload                      | per request
//  i_scan   | in  | scan_byte[7:0]               | one scancode byte
//  o_key    | out | key_code[23:0], released     | zero or one key event
//
// Event valid once the byte has passed the input register and then the output register;
// one byte per cycle unless o_key stalls, set by the prefix state update in the decode stage.
// Prefix bytes produce no event. Synchronous active-low reset clears valids and prefix state.
// A stalled event holds the decode stage; the input register still takes one byte.
module scancode_prefix_decoder (
    input  logic          i_clk,
    input  logic          i_rst_n,
    scpd_stream_if.sink   i_scan,
    scpd_stream_if.source o_key
);
    import scpd_pkg::*;

    logic      in_fire;
    logic      stg_vld;
    t_scan_req stg_req;
    logic      stg_fire;
    t_step_res res;
    logic      r_out_vld;
    logic      n_out_vld;
    t_key_evt  r_out_evt;

    assign stg_fire     = stg_vld && (!r_out_vld || o_key.ready);
    assign i_scan.ready = !stg_vld || stg_fire;
    assign in_fire      = i_scan.valid && i_scan.ready;

    scpd_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (in_fire),
        .i_req   (i_scan.payload),
        .i_take  (stg_fire),
        .o_vld   (stg_vld),
        .o_req   (stg_req)
    );

    scpd_decode u_dec (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (stg_fire),
        .i_req   (stg_req),
        .o_res   (res)
    );

    always_comb begin
        n_out_vld = r_out_vld;
        if (stg_fire && res.has) begin
            n_out_vld = 1'b1;
        end else if (o_key.ready) begin
            n_out_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (stg_fire && res.has) begin
            r_out_evt <= res.evt;
        end
    end

    assign o_key.valid   = r_out_vld;
    assign o_key.payload = r_out_evt;

    a_ready_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_scan.ready |-> stg_vld)
        else $error("input stalled with empty stage");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !o_key.ready) |-> !stg_fire)
        else $error("decode fired into a stalled output");

    a_event_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (stg_fire && res.has) |=> o_key.valid)
        else $error("decoded event not presented");

    a_idle_after_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_key.valid)
        else $error("event valid right after reset");
endmodule

>>> src/scpd_in_stage.sv
// Input register stage of the scancode prefix decoder.
// Depends on scpd_pkg for the request type.
module scpd_in_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  scpd_pkg::t_scan_req i_req,
    input  logic                i_take,
    output logic                o_vld,
    output scpd_pkg::t_scan_req o_req
);
    import scpd_pkg::*;

    logic      r_vld;
    logic      n_vld;
    t_scan_req r_req;

    always_comb begin
        n_vld = r_vld;
        if (i_load) begin
            n_vld = 1'b1;
        end else if (i_take) begin
            n_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_req <= i_req;
        end
    end

    assign o_vld = r_vld;
    assign o_req = r_req;
endmodule

>>> src/scpd_decode.sv
// Prefix state machine and key code assembly, one byte per fire.
// Depends on scpd_pkg for mode encoding, constants and result type.
module scpd_decode (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_fire,
    input  scpd_pkg::t_scan_req i_req,
    output scpd_pkg::t_step_res o_res
);
    import scpd_pkg::*;

    t_mode             r_mode;
    t_mode             n_mode;
    logic [1:0]        r_left;
    logic [1:0]        n_left;
    logic [CODE_W-1:0] r_accum;
    logic [CODE_W-1:0] n_accum;
    logic              has;
    logic [BYTE_W-1:0] b;
    logic [6:0]        low7;
    logic [1:0]        left_dec;
    logic [CODE_W-1:0] shifted;

    assign b        = i_req.scan_byte;
    assign low7     = b[6:0];
    assign left_dec = r_left - 2'd1;
    assign shifted  = {r_accum[15:0], 1'b0, low7};

    always_comb begin
        n_mode  = r_mode;
        n_left  = r_left;
        n_accum = r_accum;
        has     = 1'b0;
        unique case (r_mode)
            MODE_NONE: begin
                if (b == SC_EXT) begin
                    n_mode  = MODE_EXT;
                    n_left  = LEFT_EXT;
                    n_accum = '0;
                end else if (b == SC_PAUSE) begin
                    n_mode  = MODE_PAUSE;
                    n_left  = LEFT_PAUSE;
                    n_accum = CODE_PAUSE_SEED;
                end else begin
                    n_accum = {17'd0, low7};
                    has     = 1'b1;
                end
            end
            MODE_EXT: begin
                if (b == SC_PRT_MAKE || b == SC_PRT_BRK) begin
                    n_accum = CODE_PRT_BASE | {17'd0, low7};
                    n_mode  = MODE_PRINT;
                end else begin
                    n_accum = {9'd0, low7, 8'd0};
                    n_left  = left_dec;
                    if (left_dec == 2'd0) begin
                        n_mode = MODE_NONE;
                        has    = 1'b1;
                    end
                end
            end
            MODE_PAUSE: begin
                n_accum = shifted;
                n_left  = left_dec;
                if (left_dec == 2'd0) begin
                    n_mode = MODE_NONE;
                    has    = 1'b1;
                end
            end
            MODE_PRINT: begin
                if (b != SC_EXT) begin
                    n_accum = shifted;
                    n_left  = left_dec;
                    if (left_dec == 2'd0) begin
                        if (shifted == CODE_PRT_RAW) begin
                            n_accum = CODE_PRT_NORM;
                        end
                        n_mode = MODE_NONE;
                        has    = 1'b1;
                    end
                end
            end
            default: begin
                n_mode = MODE_NONE;
                n_left = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_NONE;
            r_left  <= '0;
            r_accum <= '0;
        end else if (i_fire) begin
            r_mode  <= n_mode;
            r_left  <= n_left;
            r_accum <= n_accum;
        end
    end

    assign o_res.has          = has;
    assign o_res.evt.key_code = n_accum;
    assign o_res.evt.released = b[7];
endmodule
